// ===== hdl/joint_friction_torque_model_macros.svh =====
// Assertion macros for the joint friction torque model.
// Taken in by the top level; no other dependencies.
`ifndef JOINT_FRICTION_TORQUE_MODEL_MACROS_SVH
`define JOINT_FRICTION_TORQUE_MODEL_MACROS_SVH

// Same-cycle implication, disabled during reset
`define JFTM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jftm check failed");

// Next-cycle implication, disabled during reset
`define JFTM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jftm check failed");

`endif

// ===== hdl/jftm_pkg.sv =====
// Shared types, constants and functions of the joint friction torque model.
// No dependencies; every other file but the macros header imports it.
`default_nettype none

package jftm_pkg;

   localparam int NUM_JOINTS  = 7;
   localparam int NUM_STAGES  = 8;
   localparam int TANH_DEPTH  = 256;
   localparam int TANH_IDX_W  = $clog2(TANH_DEPTH);
   localparam int TANH_FRAC_W = 30 - TANH_IDX_W;

   // Mixing constants, unsigned Q0.16
   localparam logic [15:0] K_6696     = 16'd43883;
   localparam logic [15:0] K_8212     = 16'd53818;
   localparam logic [15:0] K_4106     = 16'd26909;
   localparam logic [15:0] K_40921609 = 16'd26818;
   localparam logic [15:0] K_6397     = 16'd41923;
   localparam logic [15:0] K_9817     = 16'd64337;
   localparam logic [15:0] K_96373489 = 16'd63159;
   localparam logic [15:0] K_44836416 = 16'd29384;
   localparam logic [15:0] K_54987552 = 16'd36037;
   localparam logic [15:0] K_27493776 = 16'd18018;
   localparam logic [15:0] K_67436944 = 16'd44195;
   localparam logic [15:0] K_33718472 = 16'd22098;
   localparam logic [15:0] K_16859236 = 16'd11049;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_JOINT1_GAINS = 3'd0;
   localparam csr_index_type CSR_JOINT7_GAINS = 3'd6;

   typedef struct packed {
      logic signed [15:0] joint1_velocity;
      logic signed [15:0] joint2_velocity;
      logic signed [15:0] joint3_velocity;
      logic signed [15:0] joint4_velocity;
      logic signed [15:0] joint5_velocity;
      logic signed [15:0] joint6_velocity;
      logic signed [15:0] joint7_velocity;
   } req_type;

   typedef struct packed {
      logic signed [31:0] joint1_torque;
      logic signed [31:0] joint2_torque;
      logic signed [31:0] joint3_torque;
      logic signed [31:0] joint4_torque;
      logic signed [31:0] joint5_torque;
      logic signed [31:0] joint6_torque;
      logic signed [31:0] joint7_torque;
   } rsp_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] en;
      logic [NUM_STAGES-1:0] valid;
   } stage_ctrl_type;

   // tanh argument magnitude in Q.28, below four when sat is clear
   typedef struct packed {
      logic        neg;
      logic        sat;
      logic [29:0] mag;
   } tanh_in_type;

   typedef logic [15:0] tanh_rom_type [0:TANH_DEPTH];

   localparam longint unsigned TANH_ONE = 64'd1 << 30;

   // Restoring long division; evaluated only while the table is elaborated
   function automatic longint unsigned div_u64(longint unsigned n, longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], n[b]};
         if (r >= d) begin
            r    = r - d;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // Entry i holds tanh(4 i / depth) in Q1.15: exp(-2x) by series and squarings
   function automatic tanh_rom_type build_tanh_rom();
      tanh_rom_type    rom;
      longint unsigned z;
      longint unsigned term;
      longint unsigned e;
      longint unsigned num;
      longint unsigned den;
      longint unsigned y;
      longint          sum;
      for (int i = 0; i <= TANH_DEPTH; i++) begin
         z    = div_u64(64'(i) << 27, 64'(TANH_DEPTH));
         term = TANH_ONE;
         sum  = longint'(TANH_ONE);
         for (int k = 1; k <= 8; k++) begin
            term = div_u64(term * z, 64'(k) << 30);
            if ((k & 1) != 0) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         e = unsigned'(sum);
         for (int r = 0; r < 6; r++) begin
            e = (e * e + (TANH_ONE >> 1)) >> 30;
         end
         if (e > TANH_ONE) begin
            e = TANH_ONE;
         end
         num = TANH_ONE - e;
         den = TANH_ONE + e;
         y   = div_u64((num << 16) + den, den << 1);
         if (y > 64'd32767) begin
            y = 64'd32767;
         end
         rom[i] = y[15:0];
      end
      return rom;
   endfunction

   localparam tanh_rom_type TANH_ROM = build_tanh_rom();

   // Signed velocity or tanh value times an unsigned Q0.16 constant
   function automatic logic signed [32:0] mul_k(logic signed [15:0] v, logic [15:0] k);
      logic signed [32:0] a;
      logic signed [32:0] b;
      a = {{17{v[15]}}, v};
      b = {17'b0, k};
      return a * b;
   endfunction

   // Round Q.39 half up to Q16.16 and saturate
   function automatic logic signed [31:0] finish_q39(logic signed [63:0] acc);
      logic signed [63:0] r;
      r = (acc + 64'sd4194304) >>> 23;
      if (r > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (r < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return r[31:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/jftm_req_if.sv =====
// Request channel: seven joint velocities with valid/ready.
// Depends on jftm_pkg.
`default_nettype none

interface jftm_req_if;
   import jftm_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/jftm_rsp_if.sv =====
// Response channel: seven joint torques with valid/ready.
// Depends on jftm_pkg.
`default_nettype none

interface jftm_rsp_if;
   import jftm_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/jftm_pipe_ctrl.sv =====
// Stage valid bits and per-stage load enables for the datapath pipeline.
// Depends on jftm_pkg.
`default_nettype none

module jftm_pipe_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     rsp_ready,
   output jftm_pkg::stage_ctrl_type ctrl
);
   import jftm_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] en;
   logic                  en_chain;

   // A stage loads when empty or when the stage after it moves on
   always_comb begin
      en_chain = rsp_ready;
      for (int k = NUM_STAGES - 1; k >= 0; k--) begin
         en[k]    = !valid_ff[k] || en_chain;
         en_chain = en[k];
      end
      valid_in = valid_ff;
      if (en[0]) begin
         valid_in[0] = req_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (en[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.en    = en;
   assign ctrl.valid = valid_ff;

endmodule

`default_nettype wire

// ===== hdl/jftm_tanh.sv =====
// Two-stage tanh lookup: table read, then interpolation with odd symmetry.
// Depends on jftm_pkg (table contents and widths).
`default_nettype none

module jftm_tanh (
   input  logic                  clock,
   input  jftm_pkg::tanh_in_type tanh_in,
   input  logic                  en_a,
   input  logic                  en_b,
   output logic signed [15:0]    y
);
   import jftm_pkg::*;

   logic [TANH_IDX_W-1:0]  idx;
   logic [TANH_IDX_W:0]    addr;
   logic [15:0]            lo_ff;
   logic signed [16:0]     diff_ff;
   logic signed [16:0]     diff_in;
   logic [TANH_FRAC_W-1:0] frac_ff;
   logic                   neg_ff;
   logic                   sat_ff;
   logic signed [TANH_FRAC_W+17:0] prod;
   logic signed [TANH_FRAC_W+17:0] interp;
   logic signed [17:0]     ymag;
   logic signed [15:0]     ypos;
   logic signed [15:0]     y_ff;
   logic signed [15:0]     y_in;

   assign idx     = tanh_in.mag[29:TANH_FRAC_W];
   assign addr    = {1'b0, idx};
   assign diff_in = $signed({1'b0, TANH_ROM[addr + 1'b1]}) - $signed({1'b0, TANH_ROM[addr]});

   always_ff @(posedge clock) begin
      if (en_a) begin
         lo_ff   <= TANH_ROM[addr];
         diff_ff <= diff_in;
         frac_ff <= tanh_in.mag[TANH_FRAC_W-1:0];
         neg_ff  <= tanh_in.neg;
         sat_ff  <= tanh_in.sat;
      end
   end

   // Interpolation term rounds toward minus infinity
   always_comb begin
      prod   = (TANH_FRAC_W+18)'(diff_ff) * (TANH_FRAC_W+18)'($signed({1'b0, frac_ff}));
      interp = prod >>> TANH_FRAC_W;
      ymag   = $signed({2'b0, lo_ff}) + interp[17:0];
      ypos   = sat_ff ? 16'sd32767 : ymag[15:0];
      y_in   = neg_ff ? -ypos : ypos;
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

`default_nettype wire

// ===== hdl/joint_friction_torque_model.sv =====
// Joint friction torque model: eight-stage pipeline, one velocity vector per clock
// while the response is not stalled; the depth is set by the two wrist tanh lookups
// (table read plus interpolation) and the gain multiplies after them. A stalled
// response halts only the stages behind it, so requests keep flowing into empty stages.
// Gains come through the csr port: index i writes joint i+1 (viscous gain bits 15:0,
// Coulomb gain bits 31:16, signed Q8.8); indices beyond the seventh joint are ignored.
// Write gains only while the pipeline is empty.
// Depends on jftm_pkg, jftm_req_if, jftm_rsp_if, jftm_pipe_ctrl, jftm_tanh and the macros header.
`default_nettype none
`include "joint_friction_torque_model_macros.svh"

module joint_friction_torque_model (
   input  logic                    clock,
   input  logic                    reset,
   jftm_req_if.sink                req_chan,
   jftm_rsp_if.source              rsp_chan,
   input  logic                    csr_write_enable,
   input  jftm_pkg::csr_index_type csr_index,
   input  logic [31:0]             csr_write_data
);
   import jftm_pkg::*;

   localparam int NQ    = 14;
   localparam int Q409  = 0;
   localparam int Q963  = 1;
   localparam int Q448  = 2;
   localparam int Q549A = 3;
   localparam int Q274C = 4;
   localparam int Q549B = 5;
   localparam int Q674  = 6;
   localparam int Q337C = 7;
   localparam int Q274A = 8;
   localparam int Q337B = 9;
   localparam int Q168  = 10;
   localparam int QM2   = 11;
   localparam int QM3   = 12;
   localparam int QM4   = 13;

   stage_ctrl_type     ctrl;
   logic [31:0]        gains_ff [NUM_JOINTS];
   logic signed [15:0] gv [NUM_JOINTS];
   logic signed [15:0] gc [NUM_JOINTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NUM_JOINTS; j++) begin
            gains_ff[j] <= '0;
         end
      end else if (csr_write_enable && csr_index <= CSR_JOINT7_GAINS) begin
         gains_ff[csr_index] <= csr_write_data;
      end
   end

   always_comb begin
      for (int j = 0; j < NUM_JOINTS; j++) begin
         gv[j] = gains_ff[j][15:0];
         gc[j] = gains_ff[j][31:16];
      end
   end

   jftm_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .ctrl      (ctrl)
   );

   assign req_chan.ready = ctrl.en[0];

   // ---- stage 1: velocity products and joint tanh arguments
   logic signed [15:0] vel [NUM_JOINTS];
   logic signed [21:0] x50 [5];
   logic [20:0]        mag_in [5];
   logic signed [32:0] q_in [NQ];
   logic signed [15:0] s1_v_ff [3];
   logic [20:0]        s1_mag_ff [5];
   logic               s1_neg_ff [5];
   logic signed [32:0] s1_q_ff [NQ];

   always_comb begin
      vel[0] = req_chan.payload.joint1_velocity;
      vel[1] = req_chan.payload.joint2_velocity;
      vel[2] = req_chan.payload.joint3_velocity;
      vel[3] = req_chan.payload.joint4_velocity;
      vel[4] = req_chan.payload.joint5_velocity;
      vel[5] = req_chan.payload.joint6_velocity;
      vel[6] = req_chan.payload.joint7_velocity;
      for (int j = 0; j < 5; j++) begin
         x50[j]    = 22'(vel[j]) * 22'sd50;
         mag_in[j] = x50[j][21] ? 21'(-x50[j]) : 21'(x50[j]);
      end
      q_in[Q409]  = mul_k(vel[3], K_40921609);
      q_in[Q963]  = mul_k(vel[4], K_96373489);
      q_in[Q448]  = mul_k(vel[4], K_44836416);
      q_in[Q549A] = mul_k(vel[5], K_54987552);
      q_in[Q274C] = mul_k(vel[6], K_27493776);
      q_in[Q549B] = mul_k(vel[4], K_54987552);
      q_in[Q674]  = mul_k(vel[5], K_67436944);
      q_in[Q337C] = mul_k(vel[6], K_33718472);
      q_in[Q274A] = mul_k(vel[4], K_27493776);
      q_in[Q337B] = mul_k(vel[5], K_33718472);
      q_in[Q168]  = mul_k(vel[6], K_16859236);
      q_in[QM2]   = mul_k(vel[4], K_6696);
      q_in[QM3]   = mul_k(vel[5], K_8212);
      q_in[QM4]   = mul_k(vel[6], K_4106);
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[0]) begin
         for (int j = 0; j < 3; j++) begin
            s1_v_ff[j] <= vel[j];
         end
         for (int j = 0; j < 5; j++) begin
            s1_mag_ff[j] <= mag_in[j];
            s1_neg_ff[j] <= x50[j][21];
         end
         for (int i = 0; i < NQ; i++) begin
            s1_q_ff[i] <= q_in[i];
         end
      end
   end

   // Joint tanh lookups: table read in stage 2, value in stage 3
   tanh_in_type        jt_in [5];
   logic signed [15:0] th [5];

   for (genvar j = 0; j < 5; j++) begin : g_joint_tanh
      always_comb begin
         jt_in[j].neg = s1_neg_ff[j];
         jt_in[j].sat = |s1_mag_ff[j][20:14];
         jt_in[j].mag = {s1_mag_ff[j][13:0], 16'b0};
      end
      jftm_tanh u_tanh (
         .clock   (clock),
         .tanh_in (jt_in[j]),
         .en_a    (ctrl.en[1]),
         .en_b    (ctrl.en[2]),
         .y       (th[j])
      );
   end

   // ---- stage 2: wrist sums and first gain products
   logic signed [34:0] a5b, a6b, a7b, wb;
   logic signed [34:0] s2_a5m_ff, s2_a5p_ff, s2_a6m_ff, s2_a6p_ff, s2_a7m_ff, s2_a7p_ff;
   logic signed [34:0] s2_w6_ff, s2_w8_ff;
   logic signed [31:0] s2_l_ff [3];
   logic signed [48:0] s2_l4_ff, s2_l5_ff;

   always_comb begin
      a5b = 35'(s1_q_ff[Q448]) + 35'(s1_q_ff[Q549A]);
      a6b = 35'(s1_q_ff[Q549B]) + 35'(s1_q_ff[Q674]);
      a7b = 35'(s1_q_ff[Q274A]) + 35'(s1_q_ff[Q337B]);
      wb  = 35'(s1_q_ff[QM2]) + 35'(s1_q_ff[QM3]);
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[1]) begin
         s2_a5m_ff <= a5b - 35'(s1_q_ff[Q274C]);
         s2_a5p_ff <= a5b + 35'(s1_q_ff[Q274C]);
         s2_a6m_ff <= a6b - 35'(s1_q_ff[Q337C]);
         s2_a6p_ff <= a6b + 35'(s1_q_ff[Q337C]);
         s2_a7m_ff <= 35'(s1_q_ff[Q168]) - a7b;
         s2_a7p_ff <= a7b + 35'(s1_q_ff[Q168]);
         s2_w6_ff  <= wb + 35'(s1_q_ff[QM4]);
         s2_w8_ff  <= wb - 35'(s1_q_ff[QM4]);
         for (int j = 0; j < 3; j++) begin
            s2_l_ff[j] <= 32'(gv[j]) * 32'(s1_v_ff[j]);
         end
         s2_l4_ff <= 49'(gv[3]) * 49'(s1_q_ff[Q409]);
         s2_l5_ff <= 49'(gv[4]) * 49'(s1_q_ff[Q963]);
      end
   end

   // ---- stage 3: viscous wrist terms, wrist tanh arguments
   logic signed [50:0] p5m, p5p, p6m, p6p, p7m, p7p;
   logic signed [41:0] w6x, w8x;
   logic signed [63:0] s3_acc_ff [NUM_JOINTS];
   logic signed [41:0] s3_x6_ff, s3_x8_ff;

   always_comb begin
      p5m = 51'(gv[5]) * 51'(s2_a5m_ff);
      p5p = 51'(gv[6]) * 51'(s2_a5p_ff);
      p6m = 51'(gv[5]) * 51'(s2_a6m_ff);
      p6p = 51'(gv[6]) * 51'(s2_a6p_ff);
      p7m = 51'(gv[5]) * 51'(s2_a7m_ff);
      p7p = 51'(gv[6]) * 51'(s2_a7p_ff);
      w6x = 42'(s2_w6_ff);
      w8x = 42'(s2_w8_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[2]) begin
         for (int j = 0; j < 3; j++) begin
            s3_acc_ff[j] <= 64'(s2_l_ff[j]) <<< 19;
         end
         s3_acc_ff[3] <= 64'(s2_l4_ff) <<< 3;
         s3_acc_ff[4] <= (64'(s2_l5_ff) + 64'(p5m) + 64'(p5p)) <<< 3;
         s3_acc_ff[5] <= (64'(p6m) + 64'(p6p)) <<< 3;
         s3_acc_ff[6] <= (64'(p7m) + 64'(p7p)) <<< 3;
         s3_x6_ff <= (w6x <<< 5) + (w6x <<< 4) + (w6x <<< 1);
         s3_x8_ff <= (w8x <<< 5) + (w8x <<< 4) + (w8x <<< 1);
      end
   end

   // Wrist tanh lookups: table read in stage 4, value in stage 5
   logic [41:0]        x6_mag, x8_mag;
   tanh_in_type        wt6_in, wt8_in;
   logic signed [15:0] t6, t8;

   always_comb begin
      x6_mag     = s3_x6_ff[41] ? 42'(-s3_x6_ff) : 42'(s3_x6_ff);
      x8_mag     = s3_x8_ff[41] ? 42'(-s3_x8_ff) : 42'(s3_x8_ff);
      wt6_in.neg = s3_x6_ff[41];
      wt6_in.sat = |x6_mag[41:30];
      wt6_in.mag = x6_mag[29:0];
      wt8_in.neg = s3_x8_ff[41];
      wt8_in.sat = |x8_mag[41:30];
      wt8_in.mag = x8_mag[29:0];
   end

   jftm_tanh u_tanh_t6 (
      .clock   (clock),
      .tanh_in (wt6_in),
      .en_a    (ctrl.en[3]),
      .en_b    (ctrl.en[4]),
      .y       (t6)
   );

   jftm_tanh u_tanh_t8 (
      .clock   (clock),
      .tanh_in (wt8_in),
      .en_a    (ctrl.en[3]),
      .en_b    (ctrl.en[4]),
      .y       (t8)
   );

   // ---- stage 4: Coulomb terms of joints 1 to 3
   logic signed [63:0] s4_acc_ff [NUM_JOINTS];
   logic signed [32:0] s4_thk3_ff, s4_thk4_ff;

   always_ff @(posedge clock) begin
      if (ctrl.en[3]) begin
         for (int j = 0; j < 3; j++) begin
            s4_acc_ff[j] <= s3_acc_ff[j] + (64'(32'(gc[j]) * 32'(th[j])) <<< 16);
         end
         for (int j = 3; j < NUM_JOINTS; j++) begin
            s4_acc_ff[j] <= s3_acc_ff[j];
         end
         s4_thk3_ff <= mul_k(th[3], K_6397);
         s4_thk4_ff <= mul_k(th[4], K_9817);
      end
   end

   // ---- stage 5: Coulomb terms of joints 4 and 5
   logic signed [63:0] s5_acc_ff [NUM_JOINTS];

   always_ff @(posedge clock) begin
      if (ctrl.en[4]) begin
         for (int j = 0; j < 3; j++) begin
            s5_acc_ff[j] <= s4_acc_ff[j];
         end
         s5_acc_ff[3] <= s4_acc_ff[3] + 64'(49'(gc[3]) * 49'(s4_thk3_ff));
         s5_acc_ff[4] <= s4_acc_ff[4] + 64'(49'(gc[4]) * 49'(s4_thk4_ff));
         s5_acc_ff[5] <= s4_acc_ff[5];
         s5_acc_ff[6] <= s4_acc_ff[6];
      end
   end

   // ---- stage 6: smoothed wrist signs times mixing constants
   logic signed [63:0] s6_acc_ff [NUM_JOINTS];
   logic signed [32:0] s6_t6k_ff [3];
   logic signed [32:0] s6_t8k_ff [3];

   always_ff @(posedge clock) begin
      if (ctrl.en[5]) begin
         for (int j = 0; j < NUM_JOINTS; j++) begin
            s6_acc_ff[j] <= s5_acc_ff[j];
         end
         s6_t6k_ff[0] <= mul_k(t6, K_6696);
         s6_t6k_ff[1] <= mul_k(t6, K_8212);
         s6_t6k_ff[2] <= mul_k(t6, K_4106);
         s6_t8k_ff[0] <= mul_k(t8, K_6696);
         s6_t8k_ff[1] <= mul_k(t8, K_8212);
         s6_t8k_ff[2] <= mul_k(t8, K_4106);
      end
   end

   // ---- stage 7: wrist Coulomb terms
   logic signed [48:0] c6 [3];
   logic signed [48:0] c8 [3];
   logic signed [63:0] s7_acc_ff [NUM_JOINTS];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c6[i] = 49'(gc[6]) * 49'(s6_t6k_ff[i]);
         c8[i] = 49'(gc[5]) * 49'(s6_t8k_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[6]) begin
         for (int j = 0; j < 4; j++) begin
            s7_acc_ff[j] <= s6_acc_ff[j];
         end
         s7_acc_ff[4] <= s6_acc_ff[4] + 64'(c6[0]) + 64'(c8[0]);
         s7_acc_ff[5] <= s6_acc_ff[5] + 64'(c6[1]) + 64'(c8[1]);
         s7_acc_ff[6] <= s6_acc_ff[6] + 64'(c6[2]) - 64'(c8[2]);
      end
   end

   // ---- stage 8: round, saturate, hold for the response
   logic signed [31:0] s8_out_ff [NUM_JOINTS];

   always_ff @(posedge clock) begin
      if (ctrl.en[7]) begin
         for (int j = 0; j < NUM_JOINTS; j++) begin
            s8_out_ff[j] <= finish_q39(s7_acc_ff[j]);
         end
      end
   end

   assign rsp_chan.valid                 = ctrl.valid[NUM_STAGES-1];
   assign rsp_chan.payload.joint1_torque = s8_out_ff[0];
   assign rsp_chan.payload.joint2_torque = s8_out_ff[1];
   assign rsp_chan.payload.joint3_torque = s8_out_ff[2];
   assign rsp_chan.payload.joint4_torque = s8_out_ff[3];
   assign rsp_chan.payload.joint5_torque = s8_out_ff[4];
   assign rsp_chan.payload.joint6_torque = s8_out_ff[5];
   assign rsp_chan.payload.joint7_torque = s8_out_ff[6];

   `JFTM_ASSERT_SAME(a_full_pipe_blocks, clock, reset, (&ctrl.valid) && !rsp_chan.ready, !req_chan.ready)
   `JFTM_ASSERT_NEXT(a_request_enters, clock, reset, req_chan.valid && req_chan.ready, ctrl.valid[0])
   `JFTM_ASSERT_SAME(a_tanh_in_range, clock, reset, ctrl.valid[4], (t6 != -16'sd32768) && (t8 != -16'sd32768))

endmodule

`default_nettype wire
